/* hdl/toa_reflectance_calibrator_unit_assert.svh */
// Assertion macros for the calibrator RTL.
// No dependencies; included inside module bodies.
`ifndef TOA_REFLECTANCE_CALIBRATOR_UNIT_ASSERT_SVH
`define TOA_REFLECTANCE_CALIBRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibrator check failed");

// Next-cycle implication, disabled during reset
`define TOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibrator check failed");

`endif

/* hdl/toa_pkg.sv */
// Types and constants for the TOA reflectance calibrator.
// No dependencies; compiled first.
`default_nettype none

package toa_pkg;

    localparam int COUNT_BITS     = 16;
    localparam int VALUE_BITS     = 32;
    localparam int OFFSET_BITS    = 40;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 40;
    localparam int PRODUCT_BITS   = VALUE_BITS + COUNT_BITS + 1;
    localparam int SUM_BITS       = PRODUCT_BITS + 1;
    localparam int FRAC_BITS      = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE        = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET       = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_FILL   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_COUNT    = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QA_FILL      = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_FILL  = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_SAT   = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_BYTES   = 4'd7;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_FILL  = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  slope_q16;
        logic [OFFSET_BITS-1:0] offset_q16;
        logic [COUNT_BITS-1:0]  input_fill;
        logic [COUNT_BITS-1:0]  saturation_count;
        logic [COUNT_BITS-1:0]  qa_fill_code;
        logic [VALUE_BITS-1:0]  output_fill;
        logic [VALUE_BITS-1:0]  output_saturated;
        logic                   swap_bytes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        slope_q16:        32'd65536,
        offset_q16:       40'd0,
        input_fill:       16'd0,
        saturation_count: 16'd255,
        qa_fill_code:     16'd1,
        output_fill:      32'hFFFF_D8F1,
        output_saturated: 32'd20000,
        swap_bytes:       1'b0
    };

    // One classified pixel waiting for the datapath
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        status_t               status;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

`default_nettype wire

/* hdl/toa_if.sv */
// Channel interfaces: pixel input, result output and configuration write.
// No dependencies.
`default_nettype none

interface toa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_sample;
    logic [15:0] qa_word;

    modport source (output valid, output raw_sample, output qa_word, input ready);
    modport sink   (input valid, input raw_sample, input qa_word, output ready);
endinterface

interface toa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pixel_value;
    logic [1:0]         pixel_status;
    logic [15:0]        count_min;
    logic [15:0]        count_max;
    logic signed [31:0] value_min;
    logic signed [31:0] value_max;
    logic [31:0]        fill_total;
    logic [31:0]        valid_total;

    modport source (output valid, output pixel_value, output pixel_status,
                    output count_min, output count_max, output value_min,
                    output value_max, output fill_total, output valid_total,
                    input ready);
    modport sink   (input valid, input pixel_value, input pixel_status,
                    input count_min, input count_max, input value_min,
                    input value_max, input fill_total, input valid_total,
                    output ready);
endinterface

interface toa_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [39:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/toa_reflectance_calibrator_unit.sv */
// Path from an accepted request to its result: queue, multiply, round/clamp,
// result register; throughput one pixel per cycle while the result side is ready,
// set by the single multiplier stage and the statistics update.
// Reset clears the configuration to its defaults, the queue, the pipeline
// valids and all statistics; no clearing pass is needed.
// Depends on toa_pkg, toa_if, toa_front, toa_queue, toa_back and the assert header.
`default_nettype none

module toa_reflectance_calibrator_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    toa_in_if.sink    pixel_in,
    toa_out_if.source pixel_out,
    toa_cfg_if.sink   cfg
);
    import toa_pkg::*;
    `include "toa_reflectance_calibrator_unit_assert.svh"

    cfg_t         cfg_reg, cfg_next;
    logic         push, pop;
    entry_t       push_entry, head;
    queue_flags_t q_flags;

    // Configuration register file, always ready
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SLOPE:       cfg_next.slope_q16        = cfg.data[VALUE_BITS-1:0];
                REG_OFFSET:      cfg_next.offset_q16       = cfg.data[OFFSET_BITS-1:0];
                REG_INPUT_FILL:  cfg_next.input_fill       = cfg.data[COUNT_BITS-1:0];
                REG_SAT_COUNT:   cfg_next.saturation_count = cfg.data[COUNT_BITS-1:0];
                REG_QA_FILL:     cfg_next.qa_fill_code     = cfg.data[COUNT_BITS-1:0];
                REG_OUTPUT_FILL: cfg_next.output_fill      = cfg.data[VALUE_BITS-1:0];
                REG_OUTPUT_SAT:  cfg_next.output_saturated = cfg.data[VALUE_BITS-1:0];
                REG_SWAP_BYTES:  cfg_next.swap_bytes       = cfg.data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    toa_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .pixel_in   (pixel_in),
        .cfg        (cfg_reg),
        .q_flags    (q_flags),
        .push       (push),
        .push_entry (push_entry)
    );

    toa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .flags      (q_flags)
    );

    toa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_flags   (q_flags),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

    // A valid result lies within the running value range
    `TOA_ASSERT_IMP(a_value_in_range, clk, rst_n,
        pixel_out.valid && pixel_out.pixel_status == ST_VALID,
        $signed(pixel_out.value_min) <= $signed(pixel_out.pixel_value) && $signed(pixel_out.pixel_value) <= $signed(pixel_out.value_max))
    // Count extrema stay ordered once a valid pixel has been seen
    `TOA_ASSERT_IMP(a_count_order, clk, rst_n,
        pixel_out.valid_total != 32'd0,
        pixel_out.count_min <= pixel_out.count_max)
    // A fill result has been counted
    `TOA_ASSERT_IMP(a_fill_counted, clk, rst_n,
        pixel_out.valid && pixel_out.pixel_status == ST_FILL,
        pixel_out.fill_total != 32'd0)
    // A full queue never takes a request
    `TOA_ASSERT_IMP(a_no_overrun, clk, rst_n, q_flags.full, !push)

endmodule

`default_nettype wire

/* hdl/toa_front.sv */
// Front end: takes a request, swaps and masks the sample, classifies it.
// Depends on toa_pkg and toa_in_if.
`default_nettype none

module toa_front #(
    parameter int SAMPLE_BITS = 16
) (
    toa_in_if.sink                  pixel_in,
    input  toa_pkg::cfg_t           cfg,
    input  toa_pkg::queue_flags_t   q_flags,
    output logic                    push,
    output toa_pkg::entry_t         push_entry
);
    import toa_pkg::*;

    localparam logic [COUNT_BITS-1:0] SAMPLE_MASK =
        COUNT_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [COUNT_BITS-1:0] swapped;
    logic [COUNT_BITS-1:0] count;

    // Byte swap only applies to full-width samples
    always_comb
    begin
        if (cfg.swap_bytes && (SAMPLE_BITS >= 16))
        begin
            swapped = {pixel_in.raw_sample[7:0], pixel_in.raw_sample[15:8]};
        end
        else
        begin
            swapped = pixel_in.raw_sample;
        end
        count = swapped & SAMPLE_MASK;
    end

    // Classification: fill wins over saturation
    always_comb
    begin
        push_entry.count = count;
        if ((count == cfg.input_fill) || (pixel_in.qa_word == cfg.qa_fill_code))
        begin
            push_entry.status = ST_FILL;
        end
        else if (count == cfg.saturation_count)
        begin
            push_entry.status = ST_SAT;
        end
        else
        begin
            push_entry.status = ST_VALID;
        end
    end

    assign pixel_in.ready = !q_flags.full;
    assign push           = pixel_in.valid && pixel_in.ready;

endmodule

`default_nettype wire

/* hdl/toa_queue.sv */
// Small FIFO between the front end and the datapath.
// Depends on toa_pkg.
`default_nettype none

module toa_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  toa_pkg::entry_t         push_entry,
    input  logic                    pop,
    output toa_pkg::entry_t         head,
    output toa_pkg::queue_flags_t   flags
);
    import toa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign flags.full  = (fill_reg == FULL_CNT);
    assign flags.empty = (fill_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = store_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/toa_back.sv */
// Back end: multiply, offset/round/clamp, then statistics and result register.
// Depends on toa_pkg and toa_out_if.
`default_nettype none

module toa_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  toa_pkg::cfg_t           cfg,
    input  toa_pkg::entry_t         head,
    input  toa_pkg::queue_flags_t   q_flags,
    output logic                    pop,
    toa_out_if.source               pixel_out
);
    import toa_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX_C = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN_C = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [SUM_BITS-1:0]   ROUND_HALF  = SUM_BITS'(1) << (FRAC_BITS - 1);
    localparam int                    Q_BITS      = SUM_BITS - FRAC_BITS;
    localparam logic [31:0]           CNT_SAT     = '1;

    logic advance;

    // Stage 1: product
    logic                           s1_valid_reg;
    logic signed [PRODUCT_BITS-1:0] s1_product_reg;
    logic [COUNT_BITS-1:0]          s1_count_reg;
    status_t                        s1_status_reg;

    // Stage 2: final pixel value
    logic                  s2_valid_reg;
    logic [VALUE_BITS-1:0] s2_value_reg;
    logic [COUNT_BITS-1:0] s2_count_reg;
    status_t               s2_status_reg;

    // Result register and running statistics
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    status_t               out_status_reg;
    logic                  seen_reg, seen_next;
    logic [COUNT_BITS-1:0] cmin_reg, cmin_next;
    logic [COUNT_BITS-1:0] cmax_reg, cmax_next;
    logic [VALUE_BITS-1:0] vmin_reg, vmin_next;
    logic [VALUE_BITS-1:0] vmax_reg, vmax_next;
    logic [31:0]           fills_reg, fills_next;
    logic [31:0]           valids_reg, valids_next;

    logic signed [SUM_BITS-1:0] sum;
    logic [Q_BITS-1:0]          quot;
    logic [VALUE_BITS-1:0]      clamped;
    logic [VALUE_BITS-1:0]      s2_value_next;

    // Whole pipeline moves when the result register can take a new request
    assign advance = !out_valid_reg || pixel_out.ready;
    assign pop     = advance && !q_flags.empty;

    // Offset, round half up, floor shift and clamp; fill and saturated pixels take their set values
    always_comb
    begin
        sum = SUM_BITS'(s1_product_reg)
            + SUM_BITS'($signed(cfg.offset_q16))
            + $signed(ROUND_HALF);
        quot = sum[SUM_BITS-1:FRAC_BITS];
        if (quot[Q_BITS-1:VALUE_BITS-1] == '0 || quot[Q_BITS-1:VALUE_BITS-1] == '1)
        begin
            clamped = quot[VALUE_BITS-1:0];
        end
        else if (quot[Q_BITS-1])
        begin
            clamped = VALUE_MIN_C;
        end
        else
        begin
            clamped = VALUE_MAX_C;
        end
        case (s1_status_reg)
            ST_FILL:  s2_value_next = cfg.output_fill;
            ST_SAT:   s2_value_next = cfg.output_saturated;
            default:  s2_value_next = clamped;
        endcase
    end

    // Statistics update for the request entering the result register
    always_comb
    begin
        seen_next   = seen_reg;
        cmin_next   = cmin_reg;
        cmax_next   = cmax_reg;
        vmin_next   = vmin_reg;
        vmax_next   = vmax_reg;
        fills_next  = fills_reg;
        valids_next = valids_reg;
        if (s2_valid_reg && s2_status_reg == ST_FILL)
        begin
            if (fills_reg != CNT_SAT)
            begin
                fills_next = fills_reg + 1'b1;
            end
        end
        else if (s2_valid_reg && s2_status_reg == ST_VALID)
        begin
            if (valids_reg != CNT_SAT)
            begin
                valids_next = valids_reg + 1'b1;
            end
            seen_next = 1'b1;
            if (!seen_reg || s2_count_reg < cmin_reg)
            begin
                cmin_next = s2_count_reg;
            end
            if (!seen_reg || s2_count_reg > cmax_reg)
            begin
                cmax_next = s2_count_reg;
            end
            if (!seen_reg || $signed(s2_value_reg) < $signed(vmin_reg))
            begin
                vmin_next = s2_value_reg;
            end
            if (!seen_reg || $signed(s2_value_reg) > $signed(vmax_reg))
            begin
                vmax_next = s2_value_reg;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            cmin_reg      <= '0;
            cmax_reg      <= '0;
            vmin_reg      <= '0;
            vmax_reg      <= '0;
            fills_reg     <= '0;
            valids_reg    <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_flags.empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            seen_reg      <= seen_next;
            cmin_reg      <= cmin_next;
            cmax_reg      <= cmax_next;
            vmin_reg      <= vmin_next;
            vmax_reg      <= vmax_next;
            fills_reg     <= fills_next;
            valids_reg    <= valids_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_product_reg <= $signed(cfg.slope_q16) * $signed({1'b0, head.count});
            s1_count_reg   <= head.count;
            s1_status_reg  <= head.status;
            s2_value_reg   <= s2_value_next;
            s2_count_reg   <= s1_count_reg;
            s2_status_reg  <= s1_status_reg;
            out_value_reg  <= s2_value_reg;
            out_status_reg <= s2_status_reg;
        end
    end

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.pixel_value  = out_value_reg;
    assign pixel_out.pixel_status = out_status_reg;
    assign pixel_out.count_min    = cmin_reg;
    assign pixel_out.count_max    = cmax_reg;
    assign pixel_out.value_min    = vmin_reg;
    assign pixel_out.value_max    = vmax_reg;
    assign pixel_out.fill_total   = fills_reg;
    assign pixel_out.valid_total  = valids_reg;

endmodule

`default_nettype wire

/* tb/toa_reflectance_calibrator_unit_tb.sv */
// Self-checking bench for the TOA reflectance calibrator: directed corner pixels,
// then randomised register settings and pixel streams, checked against a local predictor.
// Depends on toa_pkg, toa_if and the calibrator RTL.
module toa_reflectance_calibrator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import toa_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 4'hF;
    localparam longint VALUE_HI = 64'sd2147483647;
    localparam longint VALUE_LO = -64'sd2147483648;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 215;
    localparam int TAIL_REQS = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_NS = 2_000_000;

    // One queued request: either a pixel or a register write
    typedef struct packed {
        logic                      is_write;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [15:0]               raw;
        logic [15:0]               qa;
    } calib_req_t;

    typedef struct packed {
        logic signed [31:0] pixel_value;
        status_t            pixel_status;
        logic [15:0]        count_min;
        logic [15:0]        count_max;
        logic signed [31:0] value_min;
        logic signed [31:0] value_max;
        logic [31:0]        fill_total;
        logic [31:0]        valid_total;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    toa_in_if  pixel_if ();
    toa_out_if result_if ();
    toa_cfg_if cfg_port ();

    toa_reflectance_calibrator_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_if),
        .pixel_out(result_if),
        .cfg      (cfg_port)
    );

    calib_req_t    queued_requests[$];
    pixel_result_t expected_pixels[$];
    cfg_t          planned_cfg;
    cfg_t          cal_cfg;
    int            results_owed;
    int            mismatches;
    int            tx_gap;
    int            rx_stall;
    bit            tail_mode;
    int unsigned   cyc = 0;

    // Running statistics as the block should hold them
    bit                 seen_valid_px;
    logic [15:0]        low_count;
    logic [15:0]        high_count;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic [31:0]        fill_seen;
    logic [31:0]        valid_seen;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) cyc <= cyc + 1;

    // Register file after one write; extra data bits and unknown indexes drop out
    function automatic cfg_t after_write(input cfg_t c, input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            REG_SLOPE:       c.slope_q16        = d[31:0];
            REG_OFFSET:      c.offset_q16       = d;
            REG_INPUT_FILL:  c.input_fill       = d[15:0];
            REG_SAT_COUNT:   c.saturation_count = d[15:0];
            REG_QA_FILL:     c.qa_fill_code     = d[15:0];
            REG_OUTPUT_FILL: c.output_fill      = d[31:0];
            REG_OUTPUT_SAT:  c.output_saturated = d[31:0];
            REG_SWAP_BYTES:  c.swap_bytes       = d[0];
            default: ;
        endcase
        return c;
    endfunction

    // slope * count + offset in Q16.16, rounded half up, clamped to 32 bits
    function automatic logic signed [31:0] scale_count(input logic [15:0] count);
        longint acc;
        acc = longint'(signed'(cal_cfg.slope_q16)) * longint'(count)
            + longint'(signed'(cal_cfg.offset_q16)) + 64'sd32768;
        acc = acc >>> FRAC_BITS;
        if (acc > VALUE_HI)
            return 32'sh7FFF_FFFF;
        if (acc < VALUE_LO)
            return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    // Classify one pixel, update the statistics and return the result it gives
    function automatic pixel_result_t calibrate_pixel(input logic [15:0] raw,
                                                      input logic [15:0] qa);
        logic [15:0]        count;
        logic signed [31:0] value;
        pixel_result_t      r;
        count = (SAMPLE_BITS >= 16 && cal_cfg.swap_bytes) ? {raw[7:0], raw[15:8]} : raw;
        count = count & SAMPLE_MASK;
        if (count == cal_cfg.input_fill || qa == cal_cfg.qa_fill_code) begin
            r.pixel_value  = cal_cfg.output_fill;
            r.pixel_status = ST_FILL;
            if (fill_seen != '1)
                fill_seen++;
        end else if (count == cal_cfg.saturation_count) begin
            r.pixel_value  = cal_cfg.output_saturated;
            r.pixel_status = ST_SAT;
        end else begin
            value          = scale_count(count);
            r.pixel_value  = value;
            r.pixel_status = ST_VALID;
            if (valid_seen != '1)
                valid_seen++;
            if (!seen_valid_px) begin
                low_count     = count;
                high_count    = count;
                low_value     = value;
                high_value    = value;
                seen_valid_px = 1'b1;
            end else begin
                if (count < low_count)  low_count  = count;
                if (count > high_count) high_count = count;
                if (value < low_value)  low_value  = value;
                if (value > high_value) high_value = value;
            end
        end
        r.count_min   = low_count;
        r.count_max   = high_count;
        r.value_min   = low_value;
        r.value_max   = high_value;
        r.fill_total  = fill_seen;
        r.valid_total = valid_seen;
        return r;
    endfunction

    function automatic int idle_burst(input bit calm);
        if (calm || $urandom_range(0, 4) != 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    task automatic send_write(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] d);
        calib_req_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.index    = idx;
        r.data     = d;
        queued_requests.push_back(r);
        planned_cfg = after_write(planned_cfg, idx, d);
    endtask

    // Queue a pixel by its count; the raw word is byte-swapped when the plan says so
    task automatic send_count(input logic [15:0] count, input logic [15:0] qa);
        calib_req_t r;
        r     = '0;
        r.raw = planned_cfg.swap_bytes ? {count[7:0], count[15:8]} : count;
        r.qa  = qa;
        queued_requests.push_back(r);
    endtask

    // Request driver: pixels with random gaps, register writes only when idle
    always @(posedge clk or negedge rst_n) begin
        calib_req_t req;
        if (!rst_n) begin
            pixel_if.valid      <= 1'b0;
            pixel_if.raw_sample <= '0;
            pixel_if.qa_word    <= '0;
            cfg_port.valid      <= 1'b0;
            cfg_port.index      <= '0;
            cfg_port.data       <= '0;
            tail_mode           <= 1'b0;
            tx_gap = 0;
        end else begin
            tail_mode <= (queued_requests.size() < TAIL_REQS);
            if ((pixel_if.valid && !pixel_if.ready) || (cfg_port.valid && !cfg_port.ready)) begin
                // request still waiting for ready
            end else if (tx_gap > 0 || queued_requests.size() == 0) begin
                if (tx_gap > 0)
                    tx_gap--;
                pixel_if.valid <= 1'b0;
                cfg_port.valid <= 1'b0;
            end else if (queued_requests[0].is_write) begin
                pixel_if.valid <= 1'b0;
                if (!pixel_if.valid && results_owed == 0) begin
                    req = queued_requests.pop_front();
                    cfg_port.valid <= 1'b1;
                    cfg_port.index <= req.index;
                    cfg_port.data  <= req.data;
                end else begin
                    cfg_port.valid <= 1'b0;
                end
            end else begin
                req = queued_requests.pop_front();
                pixel_if.valid      <= 1'b1;
                pixel_if.raw_sample <= req.raw;
                pixel_if.qa_word    <= req.qa;
                cfg_port.valid      <= 1'b0;
                tx_gap = idle_burst(tail_mode || cyc[7]);
            end
        end
    end

    // Monitor: checks results, tracks register writes, predicts accepted pixels
    always @(posedge clk or negedge rst_n) begin
        pixel_result_t want;
        int            burst;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            results_owed    <= 0;
            rx_stall      = 0;
            cal_cfg       = CFG_RESET;
            seen_valid_px = 1'b0;
            low_count     = '0;
            high_count    = '0;
            low_value     = '0;
            high_value    = '0;
            fill_seen     = '0;
            valid_seen    = '0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result arrived with none outstanding", $time);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_value", want.pixel_value, result_if.pixel_value);
                    check_field("pixel_status", 32'(want.pixel_status),
                                32'(result_if.pixel_status));
                    check_field("count_min", 32'(want.count_min), 32'(result_if.count_min));
                    check_field("count_max", 32'(want.count_max), 32'(result_if.count_max));
                    check_field("value_min", want.value_min, result_if.value_min);
                    check_field("value_max", want.value_max, result_if.value_max);
                    check_field("fill_total", want.fill_total, result_if.fill_total);
                    check_field("valid_total", want.valid_total, result_if.valid_total);
                end
            end
            if (cfg_port.valid && cfg_port.ready)
                cal_cfg = after_write(cal_cfg, cfg_port.index, cfg_port.data);
            if (pixel_if.valid && pixel_if.ready)
                expected_pixels.push_back(calibrate_pixel(pixel_if.raw_sample, pixel_if.qa_word));
            results_owed <= expected_pixels.size();

            // random back-pressure bursts on the result side
            if (rx_stall > 0) begin
                rx_stall--;
                result_if.ready <= 1'b0;
            end else begin
                burst = idle_burst(tail_mode || (cyc[8] ^ cyc[6]));
                result_if.ready <= (burst == 0);
                rx_stall = (burst > 0) ? burst - 1 : 0;
            end
        end
    end

    initial begin
        int                       pick;
        logic [15:0]              count;
        logic [15:0]              qa;
        logic [15:0]              fill_code;
        logic [31:0]              slope;
        logic [CFG_DATA_BITS-1:0] offset;

        rst_n               = 1'b0;
        pixel_if.valid      = 1'b0;
        pixel_if.raw_sample = '0;
        pixel_if.qa_word    = '0;
        cfg_port.valid      = 1'b0;
        cfg_port.index      = '0;
        cfg_port.data       = '0;
        result_if.ready     = 1'b0;
        mismatches          = 0;
        planned_cfg         = CFG_RESET;

        // Reset settings: fill and saturation before any valid pixel, fill beats saturation
        send_count(16'd0, 16'd0);
        send_count(16'd255, 16'd0);
        send_count(16'd255, 16'd1);
        send_count(16'd100, 16'd1);
        send_count(16'd1, 16'd0);
        send_count(16'hFFFF, 16'hFFFF);
        send_count(16'd254, 16'h5555);
        send_count(16'd256, 16'hAAAA);

        // Largest gain and offset clamp high; upper data bits must be ignored
        send_write(REG_SLOPE, 40'hFF_7FFF_FFFF);
        send_write(REG_OFFSET, 40'h7F_FFFF_FFFF);
        send_write(REG_INPUT_FILL, 40'hFF_FFFF_1234);
        send_write(REG_SAT_COUNT, 40'h00_0001_FFFF);
        send_write(REG_QA_FILL, 40'hAA_AAAA_FFFF);
        send_write(REG_OUTPUT_FILL, 40'hFF_8000_0000);
        send_write(REG_OUTPUT_SAT, 40'h00_7FFF_FFFF);
        send_write(REG_UNMAPPED, 40'hFF_FFFF_FFFF);
        send_count(16'h1234, 16'd0);
        send_count(16'hFFFF, 16'd0);
        send_count(16'd2, 16'hFFFF);
        send_count(16'd2, 16'd0);
        send_count(16'd0, 16'h7FFF);

        // Most negative gain and offset clamp low, with byte swap on
        send_write(REG_SLOPE, 40'h00_8000_0000);
        send_write(REG_OFFSET, 40'h80_0000_0000);
        send_write(REG_SWAP_BYTES, 40'hFF_FFFF_FFFF);
        send_count(16'hFFFE, 16'd0);
        send_count(16'h00FF, 16'd0);

        // Zero gain: the offset alone shows rounding at exactly one half
        send_write(REG_SWAP_BYTES, 40'h0);
        send_write(REG_SLOPE, 40'h0);
        send_write(REG_OFFSET, 40'h00_0000_8000);
        send_count(16'd7, 16'd0);
        send_write(REG_OFFSET, 40'hFF_FFFF_8000);
        send_count(16'd7, 16'd0);
        send_write(REG_OFFSET, 40'hFF_FFFF_7FFF);
        send_count(16'd7, 16'd0);

        // Gain of plus and minus 1.5: halves round upwards for either sign
        send_write(REG_OFFSET, 40'h0);
        send_write(REG_SLOPE, 40'h00_0001_8000);
        send_count(16'd3, 16'd0);
        send_count(16'd5, 16'd0);
        send_write(REG_SLOPE, 40'h00_FFFE_8000);
        send_count(16'd3, 16'd0);

        // Random phases: a fresh register set, then a pixel stream aimed at it
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       slope = $urandom;
                1:       slope = $urandom_range(0, 32'h0003_0000);
                2:       slope = -$urandom_range(0, 32'h0003_0000);
                default: slope = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            if ($urandom_range(0, 2) == 0)
                offset = 40'({$urandom, $urandom});
            else
                offset = 40'($urandom_range(0, 32'h00FF_FFFF)) - 40'h80_0000;
            fill_code = 16'($urandom);
            send_write(REG_SLOPE, {8'($urandom), slope});
            send_write(REG_OFFSET, offset);
            send_write(REG_INPUT_FILL, {24'($urandom), fill_code});
            // now and then saturation and fill share a count
            send_write(REG_SAT_COUNT, {24'($urandom),
                       ($urandom_range(0, 5) == 0) ? fill_code : 16'($urandom)});
            send_write(REG_QA_FILL, 40'({$urandom, $urandom}));
            send_write(REG_OUTPUT_FILL, 40'({$urandom, $urandom}));
            send_write(REG_OUTPUT_SAT, 40'({$urandom, $urandom}));
            send_write(REG_SWAP_BYTES, 40'({$urandom, $urandom}));
            if ($urandom_range(0, 1) == 0)
                send_write(REG_UNMAPPED, 40'({$urandom, $urandom}));

            repeat (PHASE_ITEMS) begin
                pick  = $urandom_range(0, 99);
                count = 16'($urandom);
                qa    = 16'($urandom);
                if (pick < 8)
                    count = planned_cfg.input_fill;
                else if (pick < 16)
                    count = planned_cfg.saturation_count;
                else if (pick < 22)
                    qa = planned_cfg.qa_fill_code;
                else if (pick < 25) begin
                    count = planned_cfg.saturation_count;
                    qa    = planned_cfg.qa_fill_code;
                end else if (pick < 45)
                    count = 16'($urandom_range(0, 255));
                send_count(count, qa);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Run until every request is in and every result is back
        do
            @(posedge clk);
        while (queued_requests.size() != 0 || pixel_if.valid || cfg_port.valid
               || results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #TIMEOUT_NS;
        $display("status: fail");
        $finish;
    end

endmodule
